[rtl/core/wfc_pkg.sv]
// Shared types and constants for the wall-follow steering correction.
package wfc_pkg;

    localparam int DistW  = 8;
    localparam int SpeedW = 7;
    localparam int CorrW  = 3;
    localparam int TurnW  = 2;
    localparam int IdxW   = 3;
    localparam int DataW  = 8;

    // configuration register indexes
    localparam logic [IdxW-1:0] REG_NEAR_LIMIT     = 3'd0;
    localparam logic [IdxW-1:0] REG_FAR_LIMIT      = 3'd1;
    localparam logic [IdxW-1:0] REG_JUMP_THRESHOLD = 3'd2;
    localparam logic [IdxW-1:0] REG_BASE_SPEED_B   = 3'd3;
    localparam logic [IdxW-1:0] REG_BASE_SPEED_C   = 3'd4;
    localparam logic [IdxW-1:0] REG_MAX_CORRECTION = 3'd5;

    // reset values
    localparam logic [DistW-1:0]  NEAR_LIMIT_RST     = 8'd15;
    localparam logic [DistW-1:0]  FAR_LIMIT_RST      = 8'd18;
    localparam logic [DistW-1:0]  JUMP_THRESHOLD_RST = 8'd20;
    localparam logic [SpeedW-1:0] BASE_SPEED_B_RST   = 7'd48;
    localparam logic [SpeedW-1:0] BASE_SPEED_C_RST   = 7'd50;
    localparam logic [CorrW-1:0]  MAX_CORRECTION_RST = 3'd3;
    localparam logic [DistW-1:0]  PREV_DISTANCE_RST  = 8'd14;

    // turn request codes
    localparam logic [TurnW-1:0] TURN_NONE  = 2'd0;
    localparam logic [TurnW-1:0] TURN_RIGHT = 2'd1;
    localparam logic [TurnW-1:0] TURN_LEFT  = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [DistW-1:0]  near_limit;
        logic [DistW-1:0]  far_limit;
        logic [DistW-1:0]  jump_threshold;
        logic [SpeedW-1:0] base_speed_b;
        logic [SpeedW-1:0] base_speed_c;
        logic [CorrW-1:0]  max_correction;
    } cfg_t;

    typedef struct packed {
        logic [DistW-1:0]  avg_distance;
        logic [SpeedW-1:0] speed_b;
        logic [SpeedW-1:0] speed_c;
        logic              speeds_valid;
        logic [TurnW-1:0]  turn_request;
        logic [CorrW-1:0]  corr_b_out;
        logic [CorrW-1:0]  corr_c_out;
    } result_t;

endpackage

[rtl/core/wfc_cfg_regs.sv]
// Configuration register file for the wall-follow steering correction.
module wfc_cfg_regs import wfc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [DataW-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_NEAR_LIMIT:     cfg_next.near_limit     = cfg_data;
                REG_FAR_LIMIT:      cfg_next.far_limit      = cfg_data;
                REG_JUMP_THRESHOLD: cfg_next.jump_threshold = cfg_data;
                REG_BASE_SPEED_B:   cfg_next.base_speed_b   = cfg_data[SpeedW-1:0];
                REG_BASE_SPEED_C:   cfg_next.base_speed_c   = cfg_data[SpeedW-1:0];
                REG_MAX_CORRECTION: cfg_next.max_correction = cfg_data[CorrW-1:0];
                default: ;  // unmapped index: write ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit     <= NEAR_LIMIT_RST;
            cfg_reg.far_limit      <= FAR_LIMIT_RST;
            cfg_reg.jump_threshold <= JUMP_THRESHOLD_RST;
            cfg_reg.base_speed_b   <= BASE_SPEED_B_RST;
            cfg_reg.base_speed_c   <= BASE_SPEED_C_RST;
            cfg_reg.max_correction <= MAX_CORRECTION_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/wfc_step.sv]
// Correction step: classifies the distance, updates counters and state, forms the result.
module wfc_step import wfc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             advance,
    input  logic [DistW-1:0] sonar_first,
    input  logic [DistW-1:0] sonar_second,
    input  logic             bumper_pressed,
    output result_t          res
);

    logic [DistW-1:0] prev_distance_reg, prev_distance_next;
    logic [CorrW-1:0] corr_b_reg, corr_b_next;
    logic [CorrW-1:0] corr_c_reg, corr_c_next;
    dir_t             last_dir_reg, last_dir_next;

    logic [DistW:0]   sum;
    logic [DistW-1:0] avg_dist;
    logic [DistW-1:0] rise;
    logic             opening;
    logic             outward;
    logic             out_band;
    logic [CorrW:0]   cb_tmp, cc_tmp;
    logic [TurnW-1:0] turn;

    assign sum      = {1'b0, sonar_first} + {1'b0, sonar_second};
    assign avg_dist = sum[DistW:1];
    assign opening  = (avg_dist >= prev_distance_reg);
    assign rise     = avg_dist - prev_distance_reg;   // meaningful only when opening
    assign outward  = (avg_dist < cfg.near_limit) ||
                      ((avg_dist < cfg.far_limit) && !opening);
    assign out_band = (avg_dist > cfg.far_limit) || outward;

    always_comb begin
        prev_distance_next = prev_distance_reg;
        last_dir_next      = last_dir_reg;
        cb_tmp             = {1'b0, corr_b_reg};
        cc_tmp             = {1'b0, corr_c_reg};
        turn               = TURN_NONE;

        if (bumper_pressed) begin
            turn = TURN_LEFT;
        end else if (out_band) begin
            prev_distance_next = avg_dist;
            if (outward) begin
                if (last_dir_reg == DIR_RIGHT) begin
                    cb_tmp = '0;
                    cc_tmp = '0;
                end else if (corr_b_reg != '0) begin
                    cb_tmp = cb_tmp - 1'b1;
                end else begin
                    cc_tmp = cc_tmp + 1'b1;
                end
                last_dir_next = DIR_LEFT;
                if (cc_tmp > {1'b0, cfg.max_correction}) begin
                    cc_tmp = {1'b0, cfg.max_correction};
                end
            end else if (opening && (rise < cfg.jump_threshold)) begin
                if (last_dir_reg == DIR_LEFT) begin
                    cb_tmp = '0;
                    cc_tmp = '0;
                end else if (corr_c_reg != '0) begin
                    cc_tmp = cc_tmp - 1'b1;
                end else begin
                    cb_tmp = cb_tmp + 1'b1;
                end
                last_dir_next = DIR_RIGHT;
                if (cb_tmp > {1'b0, cfg.max_correction}) begin
                    cb_tmp = {1'b0, cfg.max_correction};
                end
            end else if (opening && (rise > cfg.jump_threshold)) begin
                turn = TURN_RIGHT;
            end
        end else begin
            cb_tmp = '0;
            cc_tmp = '0;
        end

        corr_b_next = cb_tmp[CorrW-1:0];
        corr_c_next = cc_tmp[CorrW-1:0];
    end

    always_comb begin
        res.avg_distance = avg_dist;
        res.speeds_valid = !bumper_pressed && out_band;
        res.turn_request = turn;
        res.corr_b_out   = corr_b_next;
        res.corr_c_out   = corr_c_next;
        res.speed_b      = '0;
        res.speed_c      = '0;
        if (res.speeds_valid) begin
            if (cfg.base_speed_b > {{(SpeedW-CorrW){1'b0}}, corr_b_next}) begin
                res.speed_b = cfg.base_speed_b - {{(SpeedW-CorrW){1'b0}}, corr_b_next};
            end
            if (cfg.base_speed_c > {{(SpeedW-CorrW){1'b0}}, corr_c_next}) begin
                res.speed_c = cfg.base_speed_c - {{(SpeedW-CorrW){1'b0}}, corr_c_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_distance_reg <= PREV_DISTANCE_RST;
            corr_b_reg        <= '0;
            corr_c_reg        <= '0;
            last_dir_reg      <= DIR_NONE;
        end else if (advance) begin
            prev_distance_reg <= prev_distance_next;
            corr_b_reg        <= corr_b_next;
            corr_c_reg        <= corr_c_next;
            last_dir_reg      <= last_dir_next;
        end
    end

endmodule

[rtl/core/wall_follow_correction.sv]
// Pipeline: an input transfer lands in the input register, then its result in the result register,
// from which it leaves when the receiver is ready (input reg, result reg).
// Throughput: one item per cycle while the receiver takes results; the counter and distance
// state close between the input register and the result register.
// Reset: synchronous, active low; clears both pipeline stages, sets the correction
// state (distance 14, counters 0, no direction) and the registers to their defaults.
// Top level of the wall-follow steering correction.
module wall_follow_correction import wfc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DistW-1:0]  s_sonar_first,
    input  logic [DistW-1:0]  s_sonar_second,
    input  logic              s_bumper_pressed,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DistW-1:0]  m_avg_distance,
    output logic [SpeedW-1:0] m_speed_b,
    output logic [SpeedW-1:0] m_speed_c,
    output logic              m_speeds_valid,
    output logic [TurnW-1:0]  m_turn_request,
    output logic [CorrW-1:0]  m_corr_b_out,
    output logic [CorrW-1:0]  m_corr_c_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IdxW-1:0]   cfg_index,
    input  logic [DataW-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t step_res;
    result_t res_reg;

    logic             in_valid_reg;
    logic [DistW-1:0] first_reg;
    logic [DistW-1:0] second_reg;
    logic             bump_reg;
    logic             out_valid_reg;
    logic             advance;

    assign cfg_ready = 1'b1;

    // the input stage moves on whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    wfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wfc_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .advance        (advance),
        .sonar_first    (first_reg),
        .sonar_second   (second_reg),
        .bumper_pressed (bump_reg),
        .res            (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            first_reg  <= s_sonar_first;
            second_reg <= s_sonar_second;
            bump_reg   <= s_bumper_pressed;
        end
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_avg_distance = res_reg.avg_distance;
    assign m_speed_b      = res_reg.speed_b;
    assign m_speed_c      = res_reg.speed_c;
    assign m_speeds_valid = res_reg.speeds_valid;
    assign m_turn_request = res_reg.turn_request;
    assign m_corr_b_out   = res_reg.corr_b_out;
    assign m_corr_c_out   = res_reg.corr_c_out;

endmodule

[dv/wall_follow_correction_tb.sv]
// Self-checking testbench for wall_follow_correction: directed table, then random phases.
module wall_follow_correction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfc_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DRAIN_TAIL      = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [DistW-1:0] first;
        logic [DistW-1:0] second;
        logic             bump;
        bit               pinned;
        result_t          want;
    } steer_row_t;

    typedef struct {
        bit      pinned;
        result_t want;
    } pin_t;

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [DistW-1:0]  s_sonar_first    = '0;
    logic [DistW-1:0]  s_sonar_second   = '0;
    logic              s_bumper_pressed = 1'b0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [DistW-1:0]  m_avg_distance;
    logic [SpeedW-1:0] m_speed_b;
    logic [SpeedW-1:0] m_speed_c;
    logic              m_speeds_valid;
    logic [TurnW-1:0]  m_turn_request;
    logic [CorrW-1:0]  m_corr_b_out;
    logic [CorrW-1:0]  m_corr_c_out;
    logic              cfg_valid        = 1'b0;
    logic              cfg_ready;
    logic [IdxW-1:0]   cfg_index        = '0;
    logic [DataW-1:0]  cfg_data         = '0;

    wall_follow_correction DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // steering state mirrored by the predictor
    cfg_t             steer_cfg;
    logic [DistW-1:0] prev_dist;
    logic [CorrW-1:0] corr_b;
    logic [CorrW-1:0] corr_c;
    dir_t             last_dir;

    result_t steer_expect_q[$];
    pin_t    pinned_q[$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    int      rx_cycle       = 0;

    function automatic result_t steer_predict(logic [DistW-1:0] first,
                                              logic [DistW-1:0] second, logic bump);
        logic [DistW:0]   sum;
        logic [DistW-1:0] d;
        int               delta, jt, nb, nc, sb, sc;
        logic             outward;
        result_t          r;
        sum     = {1'b0, first} + {1'b0, second};
        d       = sum[DistW:1];
        delta   = int'(d) - int'(prev_dist);
        jt      = int'(steer_cfg.jump_threshold);
        nb      = int'(corr_b);
        nc      = int'(corr_c);
        outward = (d < steer_cfg.near_limit) || ((d < steer_cfg.far_limit) && (delta < 0));
        r              = '0;
        r.avg_distance = d;
        r.turn_request = TURN_NONE;
        if (bump) begin
            r.turn_request = TURN_LEFT;
        end else if (d > steer_cfg.far_limit || outward) begin
            if (outward) begin
                if (last_dir == DIR_RIGHT) begin
                    nb = 0;
                    nc = 0;
                end else if (nb > 0) begin
                    nb--;
                end else begin
                    nc++;
                end
                if (nc > int'(steer_cfg.max_correction)) nc = int'(steer_cfg.max_correction);
                last_dir = DIR_LEFT;
            end else if (delta >= 0 && delta < jt) begin
                if (last_dir == DIR_LEFT) begin
                    nb = 0;
                    nc = 0;
                end else if (nc > 0) begin
                    nc--;
                end else begin
                    nb++;
                end
                if (nb > int'(steer_cfg.max_correction)) nb = int'(steer_cfg.max_correction);
                last_dir = DIR_RIGHT;
            end else if (delta > jt) begin
                r.turn_request = TURN_RIGHT;
            end
            prev_dist = d;
            sb = int'(steer_cfg.base_speed_b) - nb;
            sc = int'(steer_cfg.base_speed_c) - nc;
            // motors never reverse
            r.speed_b      = (sb < 0) ? '0 : sb[SpeedW-1:0];
            r.speed_c      = (sc < 0) ? '0 : sc[SpeedW-1:0];
            r.speeds_valid = 1'b1;
        end else begin
            nb = 0;
            nc = 0;
        end
        corr_b       = nb[CorrW-1:0];
        corr_c       = nc[CorrW-1:0];
        r.corr_b_out = corr_b;
        r.corr_c_out = corr_c;
        return r;
    endfunction

    function automatic result_t steer_result(int d, int sb, int sc, int v,
                                             logic [TurnW-1:0] turn, int cb, int cc);
        result_t r;
        r.avg_distance = d[DistW-1:0];
        r.speed_b      = sb[SpeedW-1:0];
        r.speed_c      = sc[SpeedW-1:0];
        r.speeds_valid = v[0];
        r.turn_request = turn;
        r.corr_b_out   = cb[CorrW-1:0];
        r.corr_c_out   = cc[CorrW-1:0];
        return r;
    endfunction

    function automatic steer_row_t steer_row(logic [DistW-1:0] first, logic [DistW-1:0] second,
                                             logic bump, bit pinned, result_t want);
        steer_row_t row;
        row.first  = first;
        row.second = second;
        row.bump   = bump;
        row.pinned = pinned;
        row.want   = want;
        return row;
    endfunction

    task automatic check_field(string field, logic [DistW-1:0] want, logic [DistW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // model update and scoreboard, sampled before the edge's updates land
    always @(posedge aclk) begin
        result_t want;
        pin_t    pin;
        bit      moved;
        if (!aresetn) begin
            steer_cfg.near_limit     = NEAR_LIMIT_RST;
            steer_cfg.far_limit      = FAR_LIMIT_RST;
            steer_cfg.jump_threshold = JUMP_THRESHOLD_RST;
            steer_cfg.base_speed_b   = BASE_SPEED_B_RST;
            steer_cfg.base_speed_c   = BASE_SPEED_C_RST;
            steer_cfg.max_correction = MAX_CORRECTION_RST;
            prev_dist   = PREV_DISTANCE_RST;
            corr_b      = '0;
            corr_c      = '0;
            last_dir    = DIR_NONE;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    REG_NEAR_LIMIT:     steer_cfg.near_limit     = cfg_data;
                    REG_FAR_LIMIT:      steer_cfg.far_limit      = cfg_data;
                    REG_JUMP_THRESHOLD: steer_cfg.jump_threshold = cfg_data;
                    REG_BASE_SPEED_B:   steer_cfg.base_speed_b   = cfg_data[SpeedW-1:0];
                    REG_BASE_SPEED_C:   steer_cfg.base_speed_c   = cfg_data[SpeedW-1:0];
                    REG_MAX_CORRECTION: steer_cfg.max_correction = cfg_data[CorrW-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                want  = steer_predict(s_sonar_first, s_sonar_second, s_bumper_pressed);
                // directed rows may carry a hand-written expectation
                if (pinned_q.size() != 0) begin
                    pin = pinned_q.pop_front();
                    if (pin.pinned) want = pin.want;
                end
                steer_expect_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (steer_expect_q.size() == 0) begin
                    $display("%0t: result transfer expected none, got avg_distance %0d",
                             $time, m_avg_distance);
                    mismatch_count++;
                end else begin
                    want = steer_expect_q.pop_front();
                    check_field("avg_distance", want.avg_distance, m_avg_distance);
                    check_field("speed_b", DistW'(want.speed_b), DistW'(m_speed_b));
                    check_field("speed_c", DistW'(want.speed_c), DistW'(m_speed_c));
                    check_field("speeds_valid", DistW'(want.speeds_valid),
                                DistW'(m_speeds_valid));
                    check_field("turn_request", DistW'(want.turn_request),
                                DistW'(m_turn_request));
                    check_field("corr_b_out", DistW'(want.corr_b_out), DistW'(m_corr_b_out));
                    check_field("corr_c_out", DistW'(want.corr_c_out), DistW'(m_corr_c_out));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // receiver: rotates through steady, random and bursty acceptance
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 96) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(1, 0) == 1);
            2:       m_ready <= ((rx_cycle % 11) < 3);
            default: m_ready <= ((rx_cycle % 4) != 0);
        endcase
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("wall_follow_correction verification failed");
        $finish;
    end

    task automatic send_item(logic [DistW-1:0] first, logic [DistW-1:0] second, logic bump);
        s_sonar_first    <= first;
        s_sonar_second   <= second;
        s_bumper_pressed <= bump;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // split a distance into two readings whose floor average gives it back
    task automatic send_reading(logic [DistW-1:0] d);
        int sum, first;
        sum = 2 * int'(d) + int'($urandom_range(1, 0));
        if (sum > 510) sum = 510;
        first = $urandom_range((sum > 255) ? 255 : sum, (sum > 255) ? sum - 255 : 0);
        send_item(first[DistW-1:0], DistW'(sum - first), 1'b0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (steer_expect_q.size() != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [IdxW-1:0] idx, logic [DataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(cfg_t c);
        cfg_write(REG_NEAR_LIMIT, c.near_limit);
        cfg_write(REG_FAR_LIMIT, c.far_limit);
        cfg_write(REG_JUMP_THRESHOLD, c.jump_threshold);
        cfg_write(REG_BASE_SPEED_B, DataW'(c.base_speed_b));
        cfg_write(REG_BASE_SPEED_C, DataW'(c.base_speed_c));
        cfg_write(REG_MAX_CORRECTION, DataW'(c.max_correction));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        steer_row_t plan[$];
        cfg_t       phase_cfg;
        int         trail, slope, step, target, sent, burst, gap, mode;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset: near 15, far 18, jump 20, speeds 48/50, max 3
        plan.push_back(steer_row(8'd255, 8'd255, 1'b1, 1'b1,
                                 steer_result(255, 0, 0, 0, TURN_LEFT, 0, 0)));
        plan.push_back(steer_row(8'd0, 8'd0, 1'b0, 1'b1,
                                 steer_result(0, 48, 49, 1, TURN_NONE, 0, 1)));
        plan.push_back(steer_row(8'd16, 8'd17, 1'b0, 1'b1,
                                 steer_result(16, 0, 0, 0, TURN_NONE, 0, 0)));
        plan.push_back(steer_row(8'd255, 8'd255, 1'b0, 1'b1,
                                 steer_result(255, 48, 50, 1, TURN_RIGHT, 0, 0)));
        plan.push_back(steer_row(8'd254, 8'd254, 1'b0, 1'b1,
                                 steer_result(254, 48, 50, 1, TURN_NONE, 0, 0)));
        plan.push_back(steer_row(8'd20, 8'd20, 1'b0, 1'b0, '0));   // falling, above band
        plan.push_back(steer_row(8'd25, 8'd25, 1'b0, 1'b0, '0));   // reversal clears
        plan.push_back(steer_row(8'd27, 8'd27, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd28, 8'd28, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd29, 8'd29, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd30, 8'd31, 1'b0, 1'b0, '0));   // saturates
        plan.push_back(steer_row(8'd50, 8'd50, 1'b0, 1'b0, '0));   // step equals jump
        plan.push_back(steer_row(8'd71, 8'd69, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd91, 8'd92, 1'b0, 1'b0, '0));   // jump
        plan.push_back(steer_row(8'd17, 8'd17, 1'b0, 1'b0, '0));   // closing
        plan.push_back(steer_row(8'd16, 8'd16, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd10, 8'd10, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd5, 8'd5, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd0, 8'd1, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd18, 8'd18, 1'b0, 1'b0, '0));   // on the far edge
        plan.push_back(steer_row(8'd255, 8'd0, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd0, 8'd255, 1'b1, 1'b0, '0));
        plan.push_back(steer_row(8'd170, 8'd85, 1'b0, 1'b0, '0));
        plan.push_back(steer_row(8'd85, 8'd170, 1'b1, 1'b0, '0));
        plan.push_back(steer_row(8'd3, 8'd4, 1'b0, 1'b0, '0));

        foreach (plan[i]) begin
            pinned_q.push_back('{plan[i].pinned, plan[i].want});
            send_item(plan[i].first, plan[i].second, plan[i].bump);
        end
        drain_results();

        trail = int'(PREV_DISTANCE_RST);
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_cfg = '{8'd0, 8'd0, 8'd0, 7'd0, 7'd0, 3'd0};
                1: phase_cfg = '{8'd255, 8'd255, 8'd255, 7'd100, 7'd100, 3'd7};
                2: phase_cfg = '{NEAR_LIMIT_RST, FAR_LIMIT_RST, JUMP_THRESHOLD_RST,
                                 BASE_SPEED_B_RST, BASE_SPEED_C_RST, MAX_CORRECTION_RST};
                3: phase_cfg = '{8'd60, 8'd40, 8'd5, 7'd3, 7'd100, 3'd7};  // inverted band
                default: begin
                    phase_cfg.near_limit     = DistW'($urandom_range(120, 0));
                    phase_cfg.far_limit      = DistW'(int'(phase_cfg.near_limit)
                                                      + int'($urandom_range(40, 0)));
                    phase_cfg.jump_threshold = DistW'($urandom_range(40, 0));
                    phase_cfg.base_speed_b   = SpeedW'($urandom_range(100, 0));
                    phase_cfg.base_speed_c   = SpeedW'($urandom_range(100, 0));
                    phase_cfg.max_correction = CorrW'($urandom_range(7, 0));
                end
            endcase
            apply_settings(phase_cfg);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(24, 1);
                slope = int'($urandom_range(2, 0)) - 1;
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
                    mode = $urandom_range(9, 0);
                    if (mode == 9) begin
                        send_item(DistW'($urandom), DistW'($urandom), 1'b1);
                    end else begin
                        case (mode)
                            0, 1, 2, 3: begin
                                // steady trend so the counters walk to saturation
                                step = (slope == 0) ? int'($urandom_range(2, 0)) - 1
                                                    : slope * int'($urandom_range(3, 1));
                                target = trail + step;
                            end
                            4: target = int'($urandom_range(1, 0) ? phase_cfg.near_limit
                                                                    : phase_cfg.far_limit)
                                        + int'($urandom_range(6, 0)) - 3;
                            5: target = trail + int'(phase_cfg.jump_threshold)
                                        + int'($urandom_range(2, 0)) - 1;
                            6: target = $urandom_range(1, 0) ? int'($urandom_range(3, 0))
                                                             : 255 - int'($urandom_range(3, 0));
                            default: target = $urandom_range(255, 0);
                        endcase
                        trail = (target < 0) ? 0 : (target > 255) ? 255 : target;
                        send_reading(trail[DistW-1:0]);
                    end
                    sent++;
                end
                gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                if ($urandom_range(39, 0) == 0) begin
                    drain_results();
                end else if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            // registers only change once the pipeline is empty
            drain_results();
        end

        if (mismatch_count == 0 && steer_expect_q.size() == 0) begin
            $display("wall_follow_correction verification clean");
        end else begin
            $display("wall_follow_correction verification failed");
        end
        $finish;
    end

endmodule
